// ===== hdl/sliding_window_sender_core_macros.svh =====
// ----------------------------------------------------------------------------
// Sliding window sender assertion macros
// Clocked assertion wrappers; defining NO_ASSERTIONS compiles them out.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_SENDER_CORE_MACROS_SVH
`define SLIDING_WINDOW_SENDER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// check prop on every edge outside reset
`define SWS_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("sliding window sender check failed");

// check prop on every edge, also during reset
`define SWS_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("sliding window sender check failed");

`else

`define SWS_ASSERT(label, clk, rst, prop)
`define SWS_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

// ===== hdl/sws_pkg.sv =====
// ----------------------------------------------------------------------------
// Sliding window sender package
// Field widths, codes, payload and command/status types, helper functions.
// ----------------------------------------------------------------------------
package sws_pkg;

  localparam int SEQ_SPACE  = 10;
  localparam int MAX_WINDOW = 4;
  localparam int DATA_WIDTH = 32;

  localparam int SEQ_W   = $clog2(SEQ_SPACE);
  localparam int CNT_W   = $clog2(MAX_WINDOW + 1);
  localparam int SEQ_FW  = 4;
  localparam int KIND_W  = 3;
  localparam int ACT_W   = 2;
  localparam int TIME_W  = 32;
  localparam int TMO_W   = 16;
  localparam int WLIM_W  = 3;
  localparam int CFG_DW  = 16;
  localparam int CFG_AW  = 1;

  localparam logic [ACT_W-1:0] ACT_SEND = 2'd0;
  localparam logic [ACT_W-1:0] ACT_ACK  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_TICK = 2'd2;

  localparam logic [KIND_W-1:0] KIND_SEND    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_RESEND  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ACK_OK  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_ACK_BAD = 3'd3;
  localparam logic [KIND_W-1:0] KIND_FULL    = 3'd4;

  localparam logic [CFG_AW-1:0] REG_TIMEOUT      = 1'b0;
  localparam logic [CFG_AW-1:0] REG_WINDOW_LIMIT = 1'b1;

  localparam logic [TMO_W-1:0]  TIMEOUT_RST      = 16'd10;
  localparam logic [WLIM_W-1:0] WINDOW_LIMIT_RST = 3'd4;

  typedef struct packed {
    logic [ACT_W-1:0]      action;
    logic [DATA_WIDTH-1:0] payload;
    logic [SEQ_FW-1:0]     ack_number;
  } item_t;

  typedef struct packed {
    logic [KIND_W-1:0]     kind;
    logic [SEQ_FW-1:0]     sequence_res;
    logic [DATA_WIDTH-1:0] frame_data;
    logic                  last;
  } res_t;

  typedef struct packed {
    logic latch;
    logic finish;
    logic tick;
    logic stamp_rd;
    logic walk_start;
    logic pay_rd;
    logic emit_resend;
  } cmd_t;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic             can_load;
    logic             any_outstanding;
    logic             expired;
    logic             walk_last;
  } status_t;

  function automatic logic [SEQ_W-1:0] seq_inc(input logic [SEQ_W-1:0] s);
    return (s == SEQ_W'(SEQ_SPACE - 1)) ? '0 : s + SEQ_W'(1);
  endfunction

  function automatic logic [CNT_W-1:0] win_size(input logic [WLIM_W-1:0] lim);
    int w;
    w = int'(lim);
    if (w < 1) w = 1;
    if (w > MAX_WINDOW) w = MAX_WINDOW;
    if (w > SEQ_SPACE) w = SEQ_SPACE;
    return CNT_W'(w);
  endfunction

endpackage

// ===== hdl/sws_ram.sv =====
// ----------------------------------------------------------------------------
// Sliding window sender RAM
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module sws_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 10
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/sws_ctrl.sv =====
// ----------------------------------------------------------------------------
// Sliding window sender controller
// Sequences accept, decision, timeout check and the retransmit walk.
// ----------------------------------------------------------------------------
`include "sliding_window_sender_core_macros.svh"

module sws_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  sws_pkg::status_t status,
  output sws_pkg::cmd_t    cmd
);

  import sws_pkg::*;

  typedef enum logic [2:0] {
    IDLE,
    DECIDE,
    CHECK,
    RESEND_RD,
    RESEND_EMIT
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = DECIDE;
        end
      end
      DECIDE: begin
        case (status.action)
          ACT_SEND, ACT_ACK: begin
            if (status.can_load) begin
              cmd.finish = 1'b1;
              state_next = IDLE;
            end
          end
          ACT_TICK: begin
            cmd.tick = 1'b1;
            if (status.any_outstanding) begin
              cmd.stamp_rd = 1'b1;
              state_next   = CHECK;
            end else begin
              state_next = IDLE;
            end
          end
          default: state_next = IDLE;
        endcase
      end
      CHECK: begin
        if (status.expired) begin
          cmd.walk_start = 1'b1;
          state_next     = RESEND_RD;
        end else begin
          state_next = IDLE;
        end
      end
      RESEND_RD: begin
        cmd.pay_rd = 1'b1;
        state_next = RESEND_EMIT;
      end
      RESEND_EMIT: begin
        if (status.can_load) begin
          cmd.emit_resend = 1'b1;
          state_next      = status.walk_last ? IDLE : RESEND_RD;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

  `SWS_ASSERT(a_emit_needs_room, clk, rst, cmd.emit_resend |-> status.can_load)
  `SWS_ASSERT(a_walk_end_idle, clk, rst, (cmd.emit_resend && status.walk_last) |=> in_ready)
  `SWS_ASSERT(a_finish_free, clk, rst, (cmd.finish || cmd.tick) |=> !cmd.finish && !cmd.tick)

endmodule

// ===== hdl/sws_dp.sv =====
// ----------------------------------------------------------------------------
// Sliding window sender datapath
// Window pointers, tick counter, frame stores, timeout compare, result register.
// ----------------------------------------------------------------------------
`include "sliding_window_sender_core_macros.svh"

module sws_dp (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [sws_pkg::CFG_AW-1:0] cfg_index,
  input  logic [sws_pkg::CFG_DW-1:0] cfg_data,
  input  sws_pkg::item_t             in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output sws_pkg::res_t              out_data,
  input  sws_pkg::cmd_t              cmd,
  output sws_pkg::status_t           status
);

  import sws_pkg::*;

  logic [TMO_W-1:0]      tmo_limit;
  logic [WLIM_W-1:0]     window_limit;
  logic [SEQ_W-1:0]      oldest_seq;
  logic [SEQ_W-1:0]      next_seq;
  logic [CNT_W-1:0]      outstanding;
  logic [TIME_W-1:0]     now_ticks;
  logic [SEQ_W-1:0]      walk_seq;
  logic [CNT_W-1:0]      walk_cnt;
  logic [CNT_W-1:0]      walk_cnt_inc;
  item_t                 item;
  res_t                  res_next;
  logic                  full;
  logic                  ack_ok;
  logic                  do_send;
  logic                  do_ack;
  logic                  load;
  logic [TIME_W-1:0]     age;
  logic [TIME_W-1:0]     stamp_rdata;
  logic [DATA_WIDTH-1:0] pay_rdata;
  logic                  stamp_we;
  logic [SEQ_W-1:0]      stamp_waddr;

  assign full         = (outstanding >= win_size(window_limit));
  assign ack_ok       = (outstanding != '0) && (item.ack_number == SEQ_FW'(oldest_seq));
  assign do_send      = cmd.finish && (item.action == ACT_SEND) && !full;
  assign do_ack       = cmd.finish && (item.action == ACT_ACK) && ack_ok;
  assign load         = cmd.finish || cmd.emit_resend;
  assign walk_cnt_inc = walk_cnt + CNT_W'(1);
  assign age          = now_ticks - stamp_rdata;

  assign status.action          = item.action;
  assign status.can_load        = !out_valid || out_ready;
  assign status.any_outstanding = (outstanding != '0);
  assign status.expired         = (age >= TIME_W'(tmo_limit));
  assign status.walk_last       = (walk_cnt_inc == outstanding);

  assign stamp_we    = do_send || cmd.emit_resend;
  assign stamp_waddr = cmd.emit_resend ? walk_seq : next_seq;

  sws_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (SEQ_SPACE)
  ) u_pay_ram (
    .clk   (clk),
    .we    (do_send),
    .waddr (next_seq),
    .wdata (item.payload),
    .re    (cmd.pay_rd),
    .raddr (walk_seq),
    .rdata (pay_rdata)
  );

  sws_ram #(
    .WIDTH (TIME_W),
    .DEPTH (SEQ_SPACE)
  ) u_stamp_ram (
    .clk   (clk),
    .we    (stamp_we),
    .waddr (stamp_waddr),
    .wdata (now_ticks),
    .re    (cmd.stamp_rd),
    .raddr (oldest_seq),
    .rdata (stamp_rdata)
  );

  always_comb begin
    res_next = '0;
    if (cmd.emit_resend) begin
      res_next.kind         = KIND_RESEND;
      res_next.sequence_res = SEQ_FW'(walk_seq);
      res_next.frame_data   = pay_rdata;
      res_next.last         = status.walk_last;
    end else begin
      res_next.last = 1'b1;
      case (item.action)
        ACT_SEND: begin
          res_next.sequence_res = SEQ_FW'(next_seq);
          if (full) begin
            res_next.kind = KIND_FULL;
          end else begin
            res_next.kind       = KIND_SEND;
            res_next.frame_data = item.payload;
          end
        end
        ACT_ACK: begin
          res_next.kind         = ack_ok ? KIND_ACK_OK : KIND_ACK_BAD;
          res_next.sequence_res = item.ack_number;
        end
        default: res_next.last = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tmo_limit    <= TIMEOUT_RST;
      window_limit <= WINDOW_LIMIT_RST;
      oldest_seq   <= '0;
      next_seq     <= '0;
      outstanding  <= '0;
      now_ticks    <= '0;
      walk_seq     <= '0;
      walk_cnt     <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_TIMEOUT:      tmo_limit    <= cfg_data;
          REG_WINDOW_LIMIT: window_limit <= cfg_data[WLIM_W-1:0];
          default:          tmo_limit    <= tmo_limit;
        endcase
      end
      if (cmd.tick) begin
        now_ticks <= now_ticks + TIME_W'(1);
      end
      if (do_send) begin
        next_seq    <= seq_inc(next_seq);
        outstanding <= outstanding + CNT_W'(1);
      end
      if (do_ack) begin
        oldest_seq  <= seq_inc(oldest_seq);
        outstanding <= outstanding - CNT_W'(1);
      end
      if (cmd.walk_start) begin
        walk_seq <= oldest_seq;
        walk_cnt <= '0;
      end else if (cmd.emit_resend) begin
        walk_seq <= seq_inc(walk_seq);
        walk_cnt <= walk_cnt_inc;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item <= in_data;
    end
    if (load) begin
      out_data <= res_next;
    end
  end

  `SWS_ASSERT_ALWAYS(a_reset_clears, clk, rst |=> !out_valid && (outstanding == '0))
  `SWS_ASSERT(a_window_bound, clk, rst, outstanding <= CNT_W'(MAX_WINDOW))
  `SWS_ASSERT(a_oldest_range, clk, rst, oldest_seq < SEQ_W'(SEQ_SPACE))
  `SWS_ASSERT(a_next_range, clk, rst, next_seq < SEQ_W'(SEQ_SPACE))
  `SWS_ASSERT(a_walk_in_window, clk, rst, cmd.emit_resend |-> (walk_cnt < outstanding))

endmodule

// ===== hdl/sliding_window_sender_core.sv =====
// Send or ack: item latched on accept, result loaded in DECIDE when the output is
// free, then IDLE takes the next item. Tick: from DECIDE to IDLE with no frames,
// via CHECK when the oldest stamp is read and not expired; on timeout, per frame,
// RESEND_RD reads the payload (registered), RESEND_EMIT waits on a held result.
// Synchronous reset clears pointers, counts, tick counter and registers to defaults;
// the frame stores are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// Sliding window sender core
// Go-back-N sender: numbers frames, takes in-order acks, retransmits on timeout.
// ----------------------------------------------------------------------------
module sliding_window_sender_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [sws_pkg::CFG_AW-1:0] cfg_index,
  input  logic [sws_pkg::CFG_DW-1:0] cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  sws_pkg::item_t             in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output sws_pkg::res_t              out_data
);

  import sws_pkg::*;

  cmd_t    cmd;
  status_t status;

  sws_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  sws_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

// ===== tb/sv/sliding_window_sender_core_tb.sv =====
// ----------------------------------------------------------------------------
// Sliding window sender core testbench
// Drives send, ack and tick requests through the valid/ready input, mirrors
// the go-back-N window in a local predictor and checks every result in order.
// Covers window fill, clamped limits, in-order and stray acks, timeouts with
// retransmission, back-pressure and long random traffic with random idling.
// ----------------------------------------------------------------------------
module sliding_window_sender_core_tb;
  import sws_pkg::*;

  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 180;
  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PRINT_CAP = 30;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_index = '0;
  logic [CFG_DW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  res_t out_data;

  sliding_window_sender_core dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  // window mirror
  logic [TMO_W-1:0] timeout_reg;
  logic [WLIM_W-1:0] wlimit_reg;
  logic [SEQ_FW-1:0] oldest_frame;
  logic [SEQ_FW-1:0] next_frame;
  int pend_count;
  logic [TIME_W-1:0] tick_count;
  logic [DATA_WIDTH-1:0] frame_store [SEQ_SPACE];
  logic [TIME_W-1:0] frame_stamp [SEQ_SPACE];

  res_t pending_results[$];
  int mismatches = 0;
  int cycle_count = 0;
  int holdoff_req = 0;
  int burst_left = 1;
  bit gaps_on = 1'b1;
  bit offering = 1'b0;

  initial begin
    forever #1 clk = ~clk;
  end

  task automatic log_mismatch(input string msg);
    mismatches++;
    if (mismatches <= PRINT_CAP) $display("%s", msg);
  endtask

  function automatic logic [SEQ_FW-1:0] next_seq_of(input logic [SEQ_FW-1:0] s);
    return (int'(s) >= SEQ_SPACE - 1) ? '0 : s + 1'b1;
  endfunction

  function automatic int window_room();
    int w;
    w = int'(wlimit_reg);
    if (w < 1) w = 1;
    if (w > MAX_WINDOW) w = MAX_WINDOW;
    if (w > SEQ_SPACE) w = SEQ_SPACE;
    return w;
  endfunction

  function automatic void queue_result(input logic [KIND_W-1:0] kind,
                                       input logic [SEQ_FW-1:0] seq,
                                       input logic [DATA_WIDTH-1:0] data,
                                       input logic last);
    res_t r;
    r.kind = kind;
    r.sequence_res = seq;
    r.frame_data = data;
    r.last = last;
    pending_results.push_back(r);
  endfunction

  function automatic void predict_window(input item_t it);
    logic [TIME_W-1:0] age;
    logic [SEQ_FW-1:0] s;
    case (it.action)
      ACT_SEND: begin
        if (pend_count >= window_room()) begin
          queue_result(KIND_FULL, next_frame, '0, 1'b1);
        end else begin
          frame_store[next_frame] = it.payload;
          frame_stamp[next_frame] = tick_count;
          queue_result(KIND_SEND, next_frame, it.payload, 1'b1);
          next_frame = next_seq_of(next_frame);
          pend_count++;
        end
      end
      ACT_ACK: begin
        if (pend_count > 0 && it.ack_number == oldest_frame) begin
          oldest_frame = next_seq_of(oldest_frame);
          pend_count--;
          queue_result(KIND_ACK_OK, it.ack_number, '0, 1'b1);
        end else begin
          queue_result(KIND_ACK_BAD, it.ack_number, '0, 1'b1);
        end
      end
      ACT_TICK: begin
        tick_count = tick_count + 1'b1;
        if (pend_count > 0) begin
          age = tick_count - frame_stamp[oldest_frame];
          if (age >= TIME_W'(timeout_reg)) begin
            s = oldest_frame;
            for (int i = 0; i < pend_count; i++) begin
              frame_stamp[s] = tick_count;
              queue_result(KIND_RESEND, s, frame_store[s], (i + 1 == pend_count));
              s = next_seq_of(s);
            end
          end
        end
      end
      default: ;
    endcase
  endfunction

  task automatic lower_valid();
    if (offering) begin
      in_valid <= 1'b0;
      offering = 1'b0;
    end
  endtask

  task automatic send_request(input item_t it);
    in_data <= it;
    if (!offering) begin
      in_valid <= 1'b1;
      offering = 1'b1;
    end
    do @(posedge clk); while (in_ready !== 1'b1);
    predict_window(it);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 16);
      if (gaps_on) begin
        lower_valid();
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  endtask

  task automatic send_fields(input logic [ACT_W-1:0] action,
                             input logic [DATA_WIDTH-1:0] payload,
                             input logic [SEQ_FW-1:0] ackn);
    item_t it;
    it.action = action;
    it.payload = payload;
    it.ack_number = ackn;
    send_request(it);
  endtask

  task automatic wait_drained();
    lower_valid();
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_AW-1:0] idx,
                                input logic [CFG_DW-1:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_we <= 1'b1;
    @(posedge clk);
    if (idx == REG_TIMEOUT) timeout_reg = data[TMO_W-1:0];
    else wlimit_reg = data[WLIM_W-1:0];
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic item_t make_random_item();
    item_t it;
    int pick;
    it.payload = $urandom;
    it.ack_number = 4'($urandom_range(0, 15));
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      it.action = ACT_SEND;
      case ($urandom_range(0, 15))
        0: it.payload = '0;
        1: it.payload = '1;
        default: ;
      endcase
    end else if (pick < 65) begin
      it.action = ACT_ACK;
      if (pend_count > 0 && $urandom_range(0, 3) != 0) it.ack_number = oldest_frame;
    end else if (pick < 93) begin
      it.action = ACT_TICK;
    end else begin
      it.action = ACT_UNUSED;
    end
    return it;
  endfunction

  task automatic test_window_fill();
    send_fields(ACT_SEND, '0, 4'hF);
    send_fields(ACT_SEND, '1, 4'h0);
    send_fields(ACT_SEND, 32'hA5A5_5A5A, 4'($urandom));
    send_fields(ACT_SEND, $urandom, 4'($urandom));
    send_fields(ACT_SEND, $urandom, 4'($urandom));
    send_fields(ACT_ACK, $urandom, 4'd3);
    send_fields(ACT_ACK, $urandom, 4'hF);
    send_fields(ACT_ACK, $urandom, 4'd0);
    send_fields(ACT_UNUSED, $urandom, 4'($urandom));
  endtask

  task automatic test_timeout_resend();
    wait_drained();
    write_register(REG_TIMEOUT, 16'd1);
    send_fields(ACT_TICK, $urandom, 4'($urandom));
    send_fields(ACT_ACK, $urandom, 4'd1);
    send_fields(ACT_ACK, $urandom, 4'd2);
    send_fields(ACT_ACK, $urandom, 4'd3);
    send_fields(ACT_ACK, $urandom, oldest_frame);
    send_fields(ACT_TICK, $urandom, 4'($urandom));
  endtask

  task automatic test_window_clamp();
    wait_drained();
    write_register(REG_WINDOW_LIMIT, 16'd0);
    write_register(REG_TIMEOUT, 16'd0);
    send_fields(ACT_SEND, $urandom, 4'($urandom));
    send_fields(ACT_SEND, $urandom, 4'($urandom));
    send_fields(ACT_TICK, $urandom, 4'($urandom));
    send_fields(ACT_ACK, $urandom, oldest_frame);
    wait_drained();
    write_register(REG_WINDOW_LIMIT, 16'hFFFF);
    repeat (5) send_fields(ACT_SEND, $urandom, 4'($urandom));
    send_fields(ACT_TICK, $urandom, 4'($urandom));
    wait_drained();
    write_register(REG_TIMEOUT, 16'hFFFF);
    send_fields(ACT_TICK, $urandom, 4'($urandom));
  endtask

  task automatic test_backpressure();
    wait_drained();
    write_register(REG_TIMEOUT, 16'd3);
    write_register(REG_WINDOW_LIMIT, 16'd4);
    gaps_on = 1'b0;
    holdoff_req = 80;
    repeat (24) send_request(make_random_item());
    wait_drained();
    gaps_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    int sent;
    int target;
    int total;
    logic [TMO_W-1:0] tmo;
    item_t it;
    total = 0;
    while (total < RANDOM_ITEMS) begin
      wait_drained();
      case ($urandom_range(0, 7))
        0: tmo = '0;
        1: tmo = '1;
        2: tmo = TMO_W'($urandom);
        default: tmo = TMO_W'($urandom_range(1, 10));
      endcase
      write_register(REG_TIMEOUT, tmo);
      write_register(REG_WINDOW_LIMIT, {13'($urandom), 3'($urandom_range(0, 7))});
      gaps_on = ($urandom_range(0, 3) != 0);
      target = $urandom_range(20, 45);
      sent = 0;
      while (sent < target) begin
        it = make_random_item();
        send_request(it);
        if (it.action != ACT_UNUSED) sent++;
      end
      total += sent;
    end
  endtask

  // receiver: stall pattern, plus long hold-off on request
  initial begin
    int phase;
    int hold_left;
    logic [15:0] pattern;
    phase = 0;
    hold_left = 0;
    pattern = '1;
    forever begin
      @(posedge clk);
      if (holdoff_req != 0) begin
        hold_left = holdoff_req;
        holdoff_req = 0;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= pattern[phase];
        phase++;
        if (phase == 16) begin
          phase = 0;
          pattern = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
        end
      end
    end
  end

  always @(posedge clk) begin
    res_t want;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (pending_results.size() == 0) begin
        log_mismatch($sformatf("unexpected result kind=%0d seq=%0d data=%h last=%b",
                               out_data.kind, out_data.sequence_res,
                               out_data.frame_data, out_data.last));
      end else begin
        want = pending_results.pop_front();
        if (out_data.kind !== want.kind || out_data.sequence_res !== want.sequence_res ||
            out_data.frame_data !== want.frame_data || out_data.last !== want.last)
          log_mismatch($sformatf(
            "result mismatch got kind=%0d seq=%0d data=%h last=%b want %0d %0d %h %b",
            out_data.kind, out_data.sequence_res, out_data.frame_data, out_data.last,
            want.kind, want.sequence_res, want.frame_data, want.last));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    timeout_reg = TIMEOUT_RST;
    wlimit_reg = WINDOW_LIMIT_RST;
    oldest_frame = '0;
    next_frame = '0;
    pend_count = 0;
    tick_count = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_window_fill();
    test_timeout_resend();
    test_window_clamp();
    test_backpressure();
    test_random_traffic();
    wait_drained();
    if (pending_results.size() != 0)
      log_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
